/* rtl/hc27_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register codes and mod-27 helper functions for the 2x2 Hill cipher.
// No dependencies; imported by every module of the block.
package hc27_pkg;

   typedef logic [4:0] sym_type;
   typedef logic [7:0] char_type;
   typedef logic [2:0] csr_index_type;

   localparam sym_type  SYM_OTHER   = 5'd26;
   localparam sym_type  SYM_MAX_KEY = 5'd26;
   localparam char_type CHAR_OTHER  = 8'h5F;
   localparam char_type CHAR_Z      = 8'h5A;
   localparam char_type CHAR_BASE   = 8'h40;
   localparam char_type CHAR_UP_A   = 8'h41;
   localparam char_type CHAR_UP_Y   = 8'h59;
   localparam char_type CHAR_LO_A   = 8'h61;
   localparam char_type CHAR_LO_Z   = 8'h7A;
   localparam char_type CASE_OFFSET = 8'h20;

   localparam csr_index_type CSR_KEY_R0C0 = 3'd0;
   localparam csr_index_type CSR_KEY_R0C1 = 3'd1;
   localparam csr_index_type CSR_KEY_R1C0 = 3'd2;
   localparam csr_index_type CSR_KEY_R1C1 = 3'd3;
   localparam csr_index_type CSR_MODE     = 3'd4;

   // Effective matrix applied to each pair, plus the bad-determinant flag
   typedef struct packed {
      sym_type m00;
      sym_type m01;
      sym_type m10;
      sym_type m11;
      logic    bad;
   } matrix_type;

   // Reduce an 11-bit value mod 27 by folding: 32 = 5 (mod 27)
   function automatic sym_type mod27(input logic [10:0] x);
      logic [8:0] v1;
      logic [6:0] v2;
      logic [5:0] v3;
      v1 = {3'b000, x[10:5]} * 9'd5 + {4'b0000, x[4:0]};
      v2 = {3'b000, v1[8:5]} * 7'd5 + {2'b00, v1[4:0]};
      v3 = {4'b0000, v2[6:5]} * 6'd5 + {1'b0, v2[4:0]};
      if (v3 > 6'd26) begin
         v3 = v3 - 6'd27;
      end
      return v3[4:0];
   endfunction

   function automatic logic [10:0] mul5(input sym_type a, input sym_type b);
      return {6'b000000, a} * {6'b000000, b};
   endfunction

   // Key register values 27..31 act as their residue
   function automatic sym_type reduce_key(input sym_type v);
      return (v > SYM_MAX_KEY) ? sym_type'(v - 5'd27) : v;
   endfunction

   function automatic sym_type neg27(input sym_type v);
      return (v == 5'd0) ? 5'd0 : sym_type'(5'd27 - v);
   endfunction

   // Multiplicative inverse mod 27; zero where none exists
   function automatic sym_type unit_inverse(input sym_type d);
      sym_type r;
      case (d)
         5'd1:    r = 5'd1;
         5'd2:    r = 5'd14;
         5'd4:    r = 5'd7;
         5'd5:    r = 5'd11;
         5'd7:    r = 5'd4;
         5'd8:    r = 5'd17;
         5'd10:   r = 5'd19;
         5'd11:   r = 5'd5;
         5'd13:   r = 5'd25;
         5'd14:   r = 5'd2;
         5'd16:   r = 5'd22;
         5'd17:   r = 5'd8;
         5'd19:   r = 5'd10;
         5'd20:   r = 5'd23;
         5'd22:   r = 5'd16;
         5'd23:   r = 5'd20;
         5'd25:   r = 5'd13;
         5'd26:   r = 5'd26;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_mult3(input sym_type d);
      logic r;
      case (d)
         5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic sym_type char_to_sym(input char_type c);
      char_type u;
      sym_type  r;
      u = (c >= CHAR_LO_A && c <= CHAR_LO_Z) ? char_type'(c - CASE_OFFSET) : c;
      if (u == CHAR_Z) begin
         r = 5'd0;
      end else if (u >= CHAR_UP_A && u <= CHAR_UP_Y) begin
         r = sym_type'(u - CHAR_BASE);
      end else begin
         r = SYM_OTHER;
      end
      return r;
   endfunction

   function automatic char_type sym_to_char(input sym_type s);
      char_type r;
      if (s == 5'd0) begin
         r = CHAR_Z;
      end else if (s < SYM_OTHER) begin
         r = CHAR_BASE + {3'b000, s};
      end else begin
         r = CHAR_OTHER;
      end
      return r;
   endfunction

endpackage

/* rtl/hill_cipher_2x2_mod27_top.sv */
`timescale 1ns / 1ps
// 2x2 Hill cipher mod 27, top level: key/matrix precompute and character pipeline.
// Depends on hc27_pkg, hc27_key and hc27_core.

// While rsp_ready holds, one character is accepted per cycle; every second character (or a
// character flagged as the end of the message) produces a pair of result characters, which
// leave the output register one per cycle, so a steady stream moves one character in and one
// out per cycle. A pair's closing character passes the input register, the pairing register
// and the result register before its first result appears. A key or mode write passes the
// key register, the residue/determinant register and the inverse-matrix register before it
// takes effect, which is ahead of any item accepted after the write.
module hill_cipher_2x2_mod27_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  hc27_pkg::char_type      req_in_char,
   input  logic                    req_message_end,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output hc27_pkg::char_type      rsp_out_char,
   output logic                    rsp_pair_last,
   output logic                    rsp_message_last,
   output logic                    rsp_key_bad,
   input  logic                    csr_wr_en,
   input  hc27_pkg::csr_index_type csr_index,
   input  hc27_pkg::sym_type       csr_wdata
);
   import hc27_pkg::*;

   matrix_type mat;

   hc27_key u_key (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mat       (mat)
   );

   hc27_core u_core (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_char      (req_in_char),
      .req_message_end  (req_message_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_pair_last    (rsp_pair_last),
      .rsp_message_last (rsp_message_last),
      .rsp_key_bad      (rsp_key_bad),
      .mat              (mat)
   );

endmodule

/* rtl/hc27_key.sv */
`timescale 1ns / 1ps
// Key registers and two-stage precompute of the effective cipher matrix.
// Depends on hc27_pkg.
module hc27_key (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  hc27_pkg::csr_index_type csr_index,
   input  hc27_pkg::sym_type      csr_wdata,
   output hc27_pkg::matrix_type   mat
);
   import hc27_pkg::*;

   sym_type key00_ff, key01_ff, key10_ff, key11_ff;
   logic    mode_ff;

   sym_type red00_ff, red01_ff, red10_ff, red11_ff;
   sym_type det_ff;
   logic    mode1_ff;

   matrix_type mat_ff;

   sym_type    red00_in, red01_in, red10_in, red11_in;
   sym_type    det_in;
   sym_type    inv_det;
   matrix_type mat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         key00_ff <= 5'd1;
         key01_ff <= 5'd0;
         key10_ff <= 5'd0;
         key11_ff <= 5'd1;
         mode_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY_R0C0: key00_ff <= csr_wdata;
            CSR_KEY_R0C1: key01_ff <= csr_wdata;
            CSR_KEY_R1C0: key10_ff <= csr_wdata;
            CSR_KEY_R1C1: key11_ff <= csr_wdata;
            CSR_MODE:     mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Stage 1: residues and determinant
   always_comb begin
      red00_in = reduce_key(key00_ff);
      red01_in = reduce_key(key01_ff);
      red10_in = reduce_key(key10_ff);
      red11_in = reduce_key(key11_ff);
      det_in   = mod27(mul5(red00_in, red11_in) + 11'd729 - mul5(red01_in, red10_in));
   end

   // Stage 2: adjugate times inverse determinant, select by mode
   always_comb begin
      inv_det    = unit_inverse(det_ff);
      mat_in.m00 = mode1_ff ? mod27(mul5(red11_ff, inv_det))        : red00_ff;
      mat_in.m01 = mode1_ff ? mod27(mul5(neg27(red01_ff), inv_det)) : red01_ff;
      mat_in.m10 = mode1_ff ? mod27(mul5(neg27(red10_ff), inv_det)) : red10_ff;
      mat_in.m11 = mode1_ff ? mod27(mul5(red00_ff, inv_det))        : red11_ff;
      mat_in.bad = is_mult3(det_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red00_ff <= 5'd1;
         red01_ff <= 5'd0;
         red10_ff <= 5'd0;
         red11_ff <= 5'd1;
         det_ff   <= 5'd1;
         mode1_ff <= 1'b0;
         mat_ff   <= '{m00: 5'd1, m01: 5'd0, m10: 5'd0, m11: 5'd1, bad: 1'b0};
      end else begin
         red00_ff <= red00_in;
         red01_ff <= red01_in;
         red10_ff <= red10_in;
         red11_ff <= red11_in;
         det_ff   <= det_in;
         mode1_ff <= mode_ff;
         mat_ff   <= mat_in;
      end
   end

   assign mat = mat_ff;

   a_bad_inverse_zero: assert property (@(posedge clock) disable iff (reset)
      (mode1_ff && is_mult3(det_ff)) |=> (mat_ff.m00 == 5'd0 && mat_ff.m11 == 5'd0))
      else $error("inverse of singular key not zero");

   a_entries_reduced: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (mat_ff.m00 < 5'd27 && mat_ff.m01 < 5'd27 &&
                mat_ff.m10 < 5'd27 && mat_ff.m11 < 5'd27))
      else $error("matrix entry out of range");

endmodule

/* rtl/hc27_core.sv */
`timescale 1ns / 1ps
// Character pipeline: input register, pairing stage, pair multiply and output serializer.
// Depends on hc27_pkg; matrix comes from hc27_key.
module hc27_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hc27_pkg::char_type   req_in_char,
   input  logic                 req_message_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hc27_pkg::char_type   rsp_out_char,
   output logic                 rsp_pair_last,
   output logic                 rsp_message_last,
   output logic                 rsp_key_bad,
   input  hc27_pkg::matrix_type mat
);
   import hc27_pkg::*;

   logic     in_valid_ff, in_end_ff;
   char_type in_char_ff;

   logic     held_ff;
   sym_type  held_sym_ff;

   logic     pair_valid_ff, pair_end_ff;
   sym_type  pair_a_ff, pair_b_ff;

   logic     res_valid_ff, res_idx_ff, res_end_ff, res_bad_ff;
   char_type res_c0_ff, res_c1_ff;

   logic     res_take, pair_take, in_take;
   logic     emit;
   sym_type  in_sym, pair_a_in, pair_b_in, r0, r1;
   char_type res_c0_in, res_c1_in;

   always_comb begin
      res_take  = !res_valid_ff || (rsp_ready && res_idx_ff);
      pair_take = !pair_valid_ff || res_take;
      in_take   = !in_valid_ff || pair_take;
      in_sym    = char_to_sym(in_char_ff);
      emit      = held_ff || in_end_ff;
      // odd ending pads with the other symbol (SYM_OTHER, shown as '_')
      pair_a_in = held_ff ? held_sym_ff : in_sym;
      pair_b_in = held_ff ? in_sym : SYM_OTHER;
      r0        = mod27(mul5(mat.m00, pair_a_ff) + mul5(mat.m01, pair_b_ff));
      r1        = mod27(mul5(mat.m10, pair_a_ff) + mul5(mat.m11, pair_b_ff));
      res_c0_in = mat.bad ? CHAR_OTHER : sym_to_char(r0);
      res_c1_in = mat.bad ? CHAR_OTHER : sym_to_char(r1);
   end

   assign req_ready = in_take && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_ff       <= 1'b0;
         pair_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
         res_idx_ff    <= 1'b0;
      end else begin
         if (in_take) begin
            in_valid_ff <= req_valid;
            in_char_ff  <= req_in_char;
            in_end_ff   <= req_message_end;
         end
         if (pair_take) begin
            pair_valid_ff <= in_valid_ff && emit;
            pair_a_ff     <= pair_a_in;
            pair_b_ff     <= pair_b_in;
            pair_end_ff   <= in_end_ff;
            if (in_valid_ff) begin
               held_ff     <= !held_ff && !in_end_ff;
               held_sym_ff <= in_sym;
            end
         end
         if (res_take) begin
            res_valid_ff <= pair_valid_ff;
            res_idx_ff   <= 1'b0;
            res_c0_ff    <= res_c0_in;
            res_c1_ff    <= res_c1_in;
            res_end_ff   <= pair_end_ff;
            res_bad_ff   <= mat.bad;
         end else if (rsp_ready) begin
            // first item of the pair taken, advance to the second
            res_idx_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid        = res_valid_ff;
   assign rsp_out_char     = res_idx_ff ? res_c1_ff : res_c0_ff;
   assign rsp_pair_last    = res_idx_ff;
   assign rsp_message_last = res_idx_ff && res_end_ff;
   assign rsp_key_bad      = res_bad_ff;

   a_bad_gives_other: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_bad) |-> (rsp_out_char == CHAR_OTHER))
      else $error("bad key item carries a letter");

   a_last_on_second: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_message_last) |-> rsp_pair_last)
      else $error("message end on first item of a pair");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_pair_last) |=> (rsp_valid && rsp_pair_last))
      else $error("second item of pair missing");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char == CHAR_OTHER || rsp_out_char == CHAR_Z ||
                     (rsp_out_char >= CHAR_UP_A && rsp_out_char <= CHAR_UP_Y)))
      else $error("illegal result character");

endmodule
